// ===== rtl/sbfd_pkg.sv =====
// Shared constants and types for the SBUS frame decoder.
package sbfd_pkg;

   localparam int FRAME_BYTES_DEF = 25;
   localparam int POS_W           = 5;
   localparam logic [7:0] HEADER_BYTE = 8'h0F;
   localparam int DATA_BYTES      = 22;
   localparam int CHAN_W          = 11;
   localparam int CHANNELS        = 16;
   localparam int INDEX_W         = 4;
   localparam int FRAME_W         = DATA_BYTES * 8;

   typedef logic [FRAME_W-1:0] frame_type;

   typedef struct packed {
      logic      push;
      frame_type frame;
   } push_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } head_type;

endpackage

// ===== rtl/sbfd_front.sv =====
// Front end: header hunt, byte counting and capture of the channel data bytes.
module sbfd_front #(
   parameter int FRAME_BYTES = sbfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 q_full,
   output sbfd_pkg::push_type   push
);

   localparam logic [sbfd_pkg::POS_W-1:0] LAST_POS = sbfd_pkg::POS_W'(FRAME_BYTES - 1);

   logic [sbfd_pkg::POS_W-1:0] pos_ff, pos_in;
   sbfd_pkg::frame_type        data_ff, data_in;
   logic                       accept;
   logic                       last_pos;

   // Hold the final byte of a frame until the queue has room
   assign last_pos  = (pos_ff == LAST_POS);
   assign req_stall = last_pos && q_full;
   assign accept    = req_valid && !req_stall;

   // Merge the incoming byte into its data slot and advance the position
   always_comb begin
      data_in = data_ff;
      for (int i = 0; i < sbfd_pkg::DATA_BYTES; i++) begin
         if (pos_ff == sbfd_pkg::POS_W'(i + 1)) begin
            data_in[i*8 +: 8] = req_rx_byte;
         end
      end
      pos_in = pos_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            if (req_rx_byte == sbfd_pkg::HEADER_BYTE) begin
               pos_in = sbfd_pkg::POS_W'(1);
            end
         end else if (last_pos) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Push the completed frame as its final byte is taken
   assign push.push  = accept && last_pos;
   assign push.frame = data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/sbfd_queue.sv =====
// Two-entry frame queue between the front end and the channel unpacker.
module sbfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  sbfd_pkg::push_type  push,
   input  logic                pop,
   output sbfd_pkg::head_type  head,
   output logic                full
);

   sbfd_pkg::frame_type slot_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.frame = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push.push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push.push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!push.push && pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Store the pushed frame
   always_ff @(posedge clock) begin
      if (push.push) begin
         slot_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

// ===== rtl/sbfd_back.sv =====
// Back end: shifts a queued frame out as sixteen 11-bit channel results.
module sbfd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sbfd_pkg::head_type            head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbfd_pkg::INDEX_W-1:0]  rsp_channel_index,
   output logic [sbfd_pkg::CHAN_W-1:0]   rsp_channel_value,
   output logic                          rsp_last_channel
);

   logic                         busy_ff;
   logic                         last_ff;
   logic [sbfd_pkg::INDEX_W-1:0] idx_ff;
   sbfd_pkg::frame_type          shift_ff;
   logic                         take;

   assign take = busy_ff && !rsp_stall;
   // Load the next frame when idle or when the last channel leaves
   assign pop  = head.valid && (!busy_ff || (take && last_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         last_ff <= 1'b0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
         last_ff <= 1'b0;
      end else if (take) begin
         busy_ff <= !last_ff;
         idx_ff  <= idx_ff + 1'b1;
         last_ff <= (idx_ff == sbfd_pkg::INDEX_W'(sbfd_pkg::CHANNELS - 2));
      end
   end

   // Drop the channel just delivered from the bottom of the frame
   always_ff @(posedge clock) begin
      if (pop) begin
         shift_ff <= head.frame;
      end else if (take) begin
         shift_ff <= shift_ff >> sbfd_pkg::CHAN_W;
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = shift_ff[sbfd_pkg::CHAN_W-1:0];
   assign rsp_last_channel  = last_ff;

endmodule

// ===== rtl/sbus_frame_decoder_top.sv =====
// Top level of the SBUS frame decoder.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   rx_byte[7:0]
//   rsp_      out        rsp_valid/rsp_stall   channel_index[3:0], channel_value[10:0],
//                                              last_channel
//
// One byte is taken each cycle; a frame's final byte stalls only while both
// queue slots hold frames not yet started by the unpacker.
// Each frame gives 16 results from the unpacker's shift register, one per unstalled cycle.
// An idle unpacker loads a frame from the queue after the frame is registered there.
// Reset is synchronous and clears the byte position, the queue and the unpacker.
module sbus_frame_decoder_top #(
   parameter int FRAME_BYTES = sbfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbfd_pkg::INDEX_W-1:0]  rsp_channel_index,
   output logic [sbfd_pkg::CHAN_W-1:0]   rsp_channel_value,
   output logic                          rsp_last_channel
);

   sbfd_pkg::push_type push;
   sbfd_pkg::head_type head;
   logic               q_full;
   logic               pop;

   sbfd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push)
   );

   sbfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   sbfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule

// ===== rtl/sbfd_checker.sv =====
// Port-level checks for the SBUS frame decoder, bound to the top level.
module sbfd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sbfd_pkg::INDEX_W-1:0]  rsp_channel_index,
   input logic [sbfd_pkg::CHAN_W-1:0]   rsp_channel_value,
   input logic                          rsp_last_channel
);

   localparam logic [sbfd_pkg::INDEX_W-1:0] LAST_IDX =
      sbfd_pkg::INDEX_W'(sbfd_pkg::CHANNELS - 1);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel_value)
         && $stable(rsp_channel_index))
      else $error("stalled result changed");

   // Channels of one frame follow in order
   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_channel |=>
         rsp_valid && rsp_channel_index == $past(rsp_channel_index) + 1'b1)
      else $error("channel sequence broken");

   // The last mark sits on channel fifteen only
   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_channel == (rsp_channel_index == LAST_IDX)))
      else $error("last mark on wrong channel");

   // A new run of results starts at channel zero
   a_rsp_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_channel_index == '0)
      else $error("frame did not start at channel zero");

endmodule

bind sbus_frame_decoder_top sbfd_checker u_sbfd_checker (.*);
